FILE: rtl/core/first_fit_heap_allocator_unit_assert.svh
// Assertion macros used by the allocator checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FFHA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ffha: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define FFHA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ffha: next-cycle check failed");

`endif

FILE: rtl/core/ffha_pkg.sv
// Shared constants, types and helpers of the first-fit heap allocator.
`default_nettype none

package ffha_pkg;

  // Arena geometry
  localparam int unsigned ARENA_BYTES  = 1024;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned ALIGN_BYTES  = 16;
  localparam int unsigned HDR_PAD      =
    (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
  localparam int unsigned NGRAN        = ARENA_BYTES / ALIGN_BYTES;
  localparam int unsigned G_W          = $clog2(NGRAN);
  localparam int unsigned ALIGN_SH     = $clog2(ALIGN_BYTES);
  localparam int unsigned HDR_GRAN     = HDR_PAD / ALIGN_BYTES;

  // Field widths
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned REQ_W   = 10;
  localparam int unsigned OFF_W   = 10;
  localparam int unsigned SLACK_W = 11;

  localparam logic [SLACK_W-1:0] SLACK_RESET = SLACK_W'(16);
  localparam int unsigned        LEN_RESET   = ARENA_BYTES - HDR_PAD;

  // Width of a next-granule sum: base granule plus length in granules plus header
  localparam int unsigned NXT_W =
    ((G_W > (LEN_W - ALIGN_SH)) ? G_W : (LEN_W - ALIGN_SH)) + 2;
  // Width of the split threshold sum
  localparam int unsigned THR_W = LEN_W + 2;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOFIT   = 2'd1,
    STATUS_BADFREE = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] free_offset;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [OFF_W-1:0] data_offset;
  } resp_t;

  // One granule record of the block table
  typedef struct packed {
    logic             start;
    logic             used;
    logic [LEN_W-1:0] len;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ASTEP,
    OP_AFIT,
    OP_ACOMMIT,
    OP_AFAIL,
    OP_FBAD,
    OP_FCLEAR,
    OP_CREAD,
    OP_CCUR,
    OP_CMERGE,
    OP_CMOVE,
    OP_CEND
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic ent_ok;   // entry just read is a real block start
    logic fit;      // free and long enough for the padded request
    logic free_ok;  // free request names a used block start
    logic merge;    // current and next block are both free
  } dp_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AEVAL,
    S_AWRITE,
    S_FCHECK,
    S_CREAD,
    S_CCUR,
    S_CNEXT,
    S_RESP
  } state_e;

  // Table contents after reset: one free block spanning the arena
  function automatic entry_t reset_entry(input logic [G_W-1:0] g);
    entry_t e;
    e = '0;
    if (g == '0) begin
      e.start = 1'b1;
      e.len   = LEN_W'(LEN_RESET);
    end
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ffha_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ffha_ctrl.sv
// Controller state machine sequencing allocate and free requests.
`default_nettype none

module ffha_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  ffha_pkg::cmd_e     cmd_i,
  input  ffha_pkg::dp_stat_t stat_i,
  output ffha_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o,
  output logic               resp_valid_o
);

  ffha_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffha_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = ffha_pkg::OP_NONE;
    unique case (state_q)
      ffha_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.op = ffha_pkg::OP_LOAD;
          state_d  = (cmd_i == ffha_pkg::CMD_FREE) ? ffha_pkg::S_FCHECK : ffha_pkg::S_AEVAL;
        end
      end
      // first-fit walk, one block a cycle
      ffha_pkg::S_AEVAL: begin
        priority if (!stat_i.ent_ok) begin
          cmd_o.op = ffha_pkg::OP_AFAIL;
          state_d  = ffha_pkg::S_RESP;
        end else if (stat_i.fit) begin
          cmd_o.op = ffha_pkg::OP_AFIT;
          state_d  = ffha_pkg::S_AWRITE;
        end else begin
          cmd_o.op = ffha_pkg::OP_ASTEP;
        end
      end
      ffha_pkg::S_AWRITE: begin
        cmd_o.op = ffha_pkg::OP_ACOMMIT;
        state_d  = ffha_pkg::S_RESP;
      end
      ffha_pkg::S_FCHECK: begin
        if (stat_i.free_ok) begin
          cmd_o.op = ffha_pkg::OP_FCLEAR;
          state_d  = ffha_pkg::S_CREAD;
        end else begin
          cmd_o.op = ffha_pkg::OP_FBAD;
          state_d  = ffha_pkg::S_RESP;
        end
      end
      // coalescing walk from the bottom of the arena
      ffha_pkg::S_CREAD: begin
        cmd_o.op = ffha_pkg::OP_CREAD;
        state_d  = ffha_pkg::S_CCUR;
      end
      ffha_pkg::S_CCUR: begin
        cmd_o.op = ffha_pkg::OP_CCUR;
        state_d  = ffha_pkg::S_CNEXT;
      end
      ffha_pkg::S_CNEXT: begin
        priority if (!stat_i.ent_ok) begin
          cmd_o.op = ffha_pkg::OP_CEND;
          state_d  = ffha_pkg::S_RESP;
        end else if (stat_i.merge) begin
          cmd_o.op = ffha_pkg::OP_CMERGE;
        end else begin
          cmd_o.op = ffha_pkg::OP_CMOVE;
        end
      end
      ffha_pkg::S_RESP: begin
        state_d = ffha_pkg::S_IDLE;
      end
      default: begin
        state_d = ffha_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o       = (state_q != ffha_pkg::S_IDLE);
  assign resp_valid_o = (state_q == ffha_pkg::S_RESP);

endmodule

`default_nettype wire

FILE: rtl/core/ffha_dp.sv
// Datapath: block table, walk pointers, split and merge arithmetic, result.
`default_nettype none

module ffha_dp (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  ffha_pkg::req_t               req_i,
  input  ffha_pkg::dp_cmd_t            cmd_i,
  input  wire                          cfg_we_i,
  input  wire  [ffha_pkg::SLACK_W-1:0] cfg_wdata_i,
  output ffha_pkg::dp_stat_t           stat_o,
  output ffha_pkg::resp_t              resp_o
);

  localparam int unsigned GW = ffha_pkg::G_W;
  localparam int unsigned LW = ffha_pkg::LEN_W;
  localparam int unsigned NW = ffha_pkg::NXT_W;
  localparam int unsigned TW = ffha_pkg::THR_W;
  localparam int unsigned OW = ffha_pkg::OFF_W;

  // Table RAM ports
  logic                         ram_we;
  logic [GW-1:0]                ram_waddr;
  ffha_pkg::entry_t             ram_wdata;
  logic                         ram_re;
  logic [GW-1:0]                ram_raddr;
  logic [ffha_pkg::ENTRY_W-1:0] ram_rdata;

  // Control-side state
  logic [ffha_pkg::NGRAN-1:0]   valid_q;
  logic [ffha_pkg::SLACK_W-1:0] slack_q;

  // Walk state
  logic [GW-1:0]    g_q, g_d;
  logic [GW-1:0]    h_q, h_d;
  logic             ovf_q, ovf_d;
  logic             bad_q, bad_d;
  logic             split_q, split_d;
  logic             dirty_q, dirty_d;
  logic [LW-1:0]    padded_q, padded_d;
  ffha_pkg::entry_t cur_q, cur_d;
  logic [GW-1:0]    rd_addr_q;
  logic             rd_vld_q;
  ffha_pkg::resp_t  resp_q, resp_d;

  // Combinational helpers
  ffha_pkg::entry_t rd;
  logic [LW-1:0]    pad_sum;
  logic [LW-1:0]    pad_in;
  logic [OW-1:0]    rel;
  logic             bad_in;
  logic [GW-1:0]    free_g;
  logic [NW-1:0]    tail_h;
  logic [TW-1:0]    thresh;
  logic             split_c;
  logic [LW-1:0]    merged_len;
  logic [GW-1:0]    nxt_base;
  logic [LW-1:0]    nxt_len;
  logic [NW-1:0]    nxt;
  logic             nxt_ovf;

  ffha_ram #(
    .WIDTH (ffha_pkg::ENTRY_W),
    .DEPTH (ffha_pkg::NGRAN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entries never written read as their reset contents
  assign rd = rd_vld_q ? ffha_pkg::entry_t'(ram_rdata) : ffha_pkg::reset_entry(rd_addr_q);

  // Request decode: padded size and free offset checks
  assign pad_sum = LW'(req_i.request_bytes) + LW'(ffha_pkg::ALIGN_BYTES - 1);
  assign pad_in  = pad_sum & ~LW'(ffha_pkg::ALIGN_BYTES - 1);
  assign rel     = req_i.free_offset - OW'(ffha_pkg::HDR_PAD);
  assign free_g  = GW'(rel >> ffha_pkg::ALIGN_SH);
  assign bad_in  = (req_i.free_offset < OW'(ffha_pkg::HDR_PAD))
                || (rel[ffha_pkg::ALIGN_SH-1:0] != '0)
                || ((32'(rel) >> ffha_pkg::ALIGN_SH) >= ffha_pkg::NGRAN);

  // Split decision for the block under inspection
  assign tail_h  = NW'(g_q) + NW'(padded_q >> ffha_pkg::ALIGN_SH) + NW'(ffha_pkg::HDR_GRAN);
  assign thresh  = TW'(padded_q) + TW'(ffha_pkg::HDR_PAD) + TW'(slack_q);
  assign split_c = (TW'(rd.len) >= thresh) && (tail_h < NW'(ffha_pkg::NGRAN));

  assign merged_len = LW'(cur_q.len + LW'(ffha_pkg::HDR_PAD) + rd.len);

  // Status to the controller
  assign stat_o.ent_ok  = !ovf_q && rd.start;
  assign stat_o.fit     = !rd.used && (rd.len >= padded_q);
  assign stat_o.free_ok = !bad_q && rd.start && rd.used;
  assign stat_o.merge   = !cur_q.used && !rd.used;

  // Shared next-block adder
  always_comb begin
    nxt_base = g_q;
    nxt_len  = rd.len;
    unique case (cmd_i.op)
      ffha_pkg::OP_CMERGE: nxt_len  = merged_len;
      ffha_pkg::OP_CMOVE:  nxt_base = h_q;
      default: begin
        nxt_base = g_q;
        nxt_len  = rd.len;
      end
    endcase
  end

  assign nxt     = NW'(nxt_base) + NW'(nxt_len >> ffha_pkg::ALIGN_SH)
                 + NW'(ffha_pkg::HDR_GRAN);
  assign nxt_ovf = (nxt >= NW'(ffha_pkg::NGRAN));

  // Operation decode
  always_comb begin
    g_d       = g_q;
    h_d       = h_q;
    ovf_d     = ovf_q;
    bad_d     = bad_q;
    split_d   = split_q;
    dirty_d   = dirty_q;
    padded_d  = padded_q;
    cur_d     = cur_q;
    resp_d    = resp_q;
    ram_we    = 1'b0;
    ram_waddr = g_q;
    ram_wdata = cur_q;
    ram_re    = 1'b0;
    ram_raddr = g_q;
    unique case (cmd_i.op)
      ffha_pkg::OP_NONE: begin
      end
      // take in a request and read its first entry
      ffha_pkg::OP_LOAD: begin
        resp_d.status      = ffha_pkg::STATUS_OK;
        resp_d.data_offset = '0;
        ovf_d              = 1'b0;
        ram_re             = 1'b1;
        if (req_i.cmd == ffha_pkg::CMD_FREE) begin
          bad_d     = bad_in;
          g_d       = free_g;
          ram_raddr = free_g;
        end else begin
          padded_d  = pad_in;
          g_d       = '0;
          ram_raddr = '0;
        end
      end
      ffha_pkg::OP_ASTEP: begin
        g_d       = nxt[GW-1:0];
        ovf_d     = nxt_ovf;
        ram_re    = 1'b1;
        ram_raddr = nxt[GW-1:0];
      end
      // found a fit: write the split-off tail now, the block itself next
      ffha_pkg::OP_AFIT: begin
        cur_d   = rd;
        split_d = split_c;
        if (split_c) begin
          ram_we          = 1'b1;
          ram_waddr       = tail_h[GW-1:0];
          ram_wdata.start = 1'b1;
          ram_wdata.used  = 1'b0;
          ram_wdata.len   = rd.len - (padded_q + LW'(ffha_pkg::HDR_PAD));
        end
      end
      ffha_pkg::OP_ACOMMIT: begin
        ram_we             = 1'b1;
        ram_waddr          = g_q;
        ram_wdata.start    = 1'b1;
        ram_wdata.used     = 1'b1;
        ram_wdata.len      = split_q ? padded_q : cur_q.len;
        resp_d.data_offset = OW'((32'(g_q) << ffha_pkg::ALIGN_SH) + ffha_pkg::HDR_PAD);
      end
      ffha_pkg::OP_AFAIL: begin
        resp_d.status = ffha_pkg::STATUS_NOFIT;
      end
      ffha_pkg::OP_FBAD: begin
        resp_d.status = ffha_pkg::STATUS_BADFREE;
      end
      ffha_pkg::OP_FCLEAR: begin
        ram_we          = 1'b1;
        ram_waddr       = g_q;
        ram_wdata.start = rd.start;
        ram_wdata.used  = 1'b0;
        ram_wdata.len   = rd.len;
      end
      ffha_pkg::OP_CREAD: begin
        g_d       = '0;
        dirty_d   = 1'b0;
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      ffha_pkg::OP_CCUR: begin
        cur_d     = rd;
        h_d       = nxt[GW-1:0];
        ovf_d     = nxt_ovf;
        ram_re    = 1'b1;
        ram_raddr = nxt[GW-1:0];
      end
      // absorb the next block; the current one is written back when left
      ffha_pkg::OP_CMERGE: begin
        ram_we          = 1'b1;
        ram_waddr       = h_q;
        ram_wdata.start = 1'b0;
        ram_wdata.used  = rd.used;
        ram_wdata.len   = '0;
        cur_d.len       = merged_len;
        dirty_d         = 1'b1;
        h_d             = nxt[GW-1:0];
        ovf_d           = nxt_ovf;
        ram_re          = 1'b1;
        ram_raddr       = nxt[GW-1:0];
      end
      ffha_pkg::OP_CMOVE: begin
        ram_we    = dirty_q;
        ram_waddr = g_q;
        ram_wdata = cur_q;
        g_d       = h_q;
        cur_d     = rd;
        dirty_d   = 1'b0;
        h_d       = nxt[GW-1:0];
        ovf_d     = nxt_ovf;
        ram_re    = 1'b1;
        ram_raddr = nxt[GW-1:0];
      end
      ffha_pkg::OP_CEND: begin
        ram_we    = dirty_q;
        ram_waddr = g_q;
        ram_wdata = cur_q;
        dirty_d   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Valid bits and split slack register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      slack_q <= ffha_pkg::SLACK_RESET;
    end else begin
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        slack_q <= cfg_wdata_i;
      end
    end
  end

  // Walk and result registers
  always_ff @(posedge clk_i) begin
    g_q      <= g_d;
    h_q      <= h_d;
    ovf_q    <= ovf_d;
    bad_q    <= bad_d;
    split_q  <= split_d;
    dirty_q  <= dirty_d;
    padded_q <= padded_d;
    cur_q    <= cur_d;
    resp_q   <= resp_d;
    if (ram_re) begin
      rd_addr_q <= ram_raddr;
      rd_vld_q  <= valid_q[ram_raddr];
    end
  end

  assign resp_o = resp_q;

endmodule

`default_nettype wire

FILE: rtl/core/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator over a 1024-byte arena.
//
//  channel   signals                       handshake
//  request   req_i                         start_i high and busy_o low at a rising edge
//  result    resp_o                        resp_valid_o high for one cycle, always taken
//  config    cfg_wdata_i (split slack)     cfg_we_i high at a rising edge
//
// Allocate examines the blocks in order, the fitting one included (at most 64). A bad
// free goes from its offset check straight to the result; otherwise the used bit is
// cleared and the coalescing walk visits every block in the arena (at most 64); the
// table RAM gives one entry a cycle.
// After reset the arena holds one free block; no clearing pass is needed.
// busy_o stays high from acceptance until the result cycle; results cannot be stalled.
`default_nettype none

module first_fit_heap_allocator_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  ffha_pkg::req_t               req_i,
  output logic                         resp_valid_o,
  output ffha_pkg::resp_t              resp_o,
  input  wire                          cfg_we_i,
  input  wire  [ffha_pkg::SLACK_W-1:0] cfg_wdata_i
);

  ffha_pkg::dp_cmd_t  dp_cmd;
  ffha_pkg::dp_stat_t dp_stat;

  ffha_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .cmd_i        (req_i.cmd),
    .stat_i       (dp_stat),
    .cmd_o        (dp_cmd),
    .busy_o       (busy_o),
    .resp_valid_o (resp_valid_o)
  );

  ffha_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (dp_cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_o      (dp_stat),
    .resp_o      (resp_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/ffha_checker.sv
// Port-level checker for the heap allocator, bound to the top level.
`default_nettype none

`include "first_fit_heap_allocator_unit_assert.svh"

module ffha_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          start_i,
  input wire                          busy_o,
  input wire                          resp_valid_o,
  input ffha_pkg::resp_t              resp_o
);

  // An accepted request keeps the unit busy
  `FFHA_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)

  // A result is shown only while the request is still being served
  `FFHA_ASSERT_IMP(a_resp_in_busy, clk_i, rst_ni, resp_valid_o, busy_o)

  // One result per request: the unit is free again right after it
  `FFHA_ASSERT_NXT(a_resp_single, clk_i, rst_ni, resp_valid_o, !busy_o && !resp_valid_o)

  // Failed requests never carry an offset
  `FFHA_ASSERT_IMP(a_fail_zero, clk_i, rst_ni,
    resp_valid_o && (resp_o.status != ffha_pkg::STATUS_OK), resp_o.data_offset == '0)

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (.*);

`default_nettype wire
